### design/mpc_pkg.sv
// ----------------------------------------------------------------------------
// Methylation pileup counter package
// Shared payload types, base codes and context codes.
// ----------------------------------------------------------------------------
package mpc_pkg;

  localparam logic [2:0] BASE_A = 3'd0;
  localparam logic [2:0] BASE_C = 3'd1;
  localparam logic [2:0] BASE_G = 3'd2;
  localparam logic [2:0] BASE_T = 3'd3;
  localparam logic [2:0] BASE_N = 3'd4;

  localparam logic [1:0] CTX_CPG = 2'd0;
  localparam logic [1:0] CTX_CHH = 2'd1;
  localparam logic [1:0] CTX_CXG = 2'd2;
  localparam logic [1:0] CTX_CCG = 2'd3;

  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_EMIT  = 1'b1;

  localparam logic [0:0] CFG_CG_ONLY      = 1'b0;
  localparam logic [0:0] CFG_CHROM_LENGTH = 1'b1;

  localparam int CFG_DATA_BITS = 17;

  typedef struct packed {
    logic        command;
    logic [15:0] position;
    logic        strand;
    logic [2:0]  read_base;
    logic [2:0]  ref_before_two;
    logic [2:0]  ref_before_one;
    logic [2:0]  ref_here;
    logic [2:0]  ref_after_one;
    logic [2:0]  ref_after_two;
  } in_item_t;

  typedef struct packed {
    logic [15:0] site_position;
    logic        site_strand;
    logic [1:0]  context_res;
    logic        mutated;
    logic [15:0] unconverted;
    logic [15:0] converted;
  } out_item_t;

  // Classified operation handed from the front end to the back end.
  typedef struct packed {
    logic        emit;
    logic [15:0] position;
    logic [2:0]  lane;
    logic        site_ok;
    logic        site_strand;
    logic [1:0]  context_res;
    logic        send;
  } op_t;

  function automatic logic is_inside(input logic [2:0] b);
    return b <= BASE_N;
  endfunction

endpackage

### design/methylation_pileup_counter.sv
// ----------------------------------------------------------------------------
// Methylation pileup counter
// Per-position bisulfite base counts with emit-and-clear; results for C/G sites.
// ----------------------------------------------------------------------------
// Usage: items arrive on the in_ channel (valid/ready). A count item adds
// one read base to a position; an emit item reads and clears a position
// and, for a C or G reference site (only CpG when cg_only is set), yields one result on the out_ channel.
// Configuration is written on the cfg_ port while the block is idle.
// Each item passes through the back-end steps queue pop, read and update,
// set by the read-modify-write of the count memory, and the back end takes
// no new item until the update is done; the front end accepts items into a
// two-entry queue meanwhile. An emit goes from the queue through the read
// and update states into the result register, which drives out_valid.
// After reset the count memory is cleared by a sweep over all POSITIONS
// entries, one entry per cycle, during which no item is accepted beyond
// the queue. A stalled receiver holds the result register; the update of the
// next emit that would produce a result waits until the register is free.
// ----------------------------------------------------------------------------
module methylation_pileup_counter
  import mpc_pkg::*;
#(
  parameter int POSITIONS  = 65536,
  parameter int COUNT_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_data,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic        cg_only_r;
  logic [16:0] chrom_length_r;
  logic [16:0] limit;
  logic        q_valid, q_ready;
  op_t         q_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cg_only_r      <= 1'b0;
      chrom_length_r <= 17'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CG_ONLY:      cg_only_r      <= cfg_data[0];
        CFG_CHROM_LENGTH: chrom_length_r <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Effective limit: the smaller of chrom_length and the table size.
  assign limit = (chrom_length_r > 17'(POSITIONS)) ? 17'(POSITIONS) : chrom_length_r;

  mpc_front #(.QDEPTH(2)) u_front (
    .clk(clk), .rst_n(rst_n), .cg_only(cg_only_r), .chrom_length(limit),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  mpc_back #(.POSITIONS(POSITIONS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
    .q_data(q_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

endmodule

### design/mpc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module mpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read; a read of the address being written returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/mpc_front.sv
// ----------------------------------------------------------------------------
// Pileup front end
// Accepts items, drops out-of-range items and unusable counts, works out the
// site strand and context of emits, then pushes the rest into a short queue.
// ----------------------------------------------------------------------------
module mpc_front
  import mpc_pkg::*;
#(
  parameter int QDEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cg_only,
  input  logic [16:0] chrom_length,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  input  logic     q_ready,
  output op_t      q_data
);

  localparam int PW = $clog2(QDEPTH);

  op_t             q_mem_r [QDEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r;
  op_t             op;
  logic            keep;
  logic            push, pop;
  logic [2:0]      h, m1, m2, p1, p2;

  // Classification of the incoming item.
  always_comb begin
    h  = in_data.ref_here;
    m1 = in_data.ref_before_one;
    m2 = in_data.ref_before_two;
    p1 = in_data.ref_after_one;
    p2 = in_data.ref_after_two;
    op = '0;
    op.emit     = (in_data.command == CMD_EMIT);
    op.position = in_data.position;
    op.lane     = {in_data.strand, in_data.read_base[1:0]};
    op.site_ok  = (h == BASE_C) || (h == BASE_G);
    op.site_strand = (h == BASE_G);
    if (h == BASE_C) begin
      if (p1 == BASE_G) begin
        op.context_res = CTX_CPG;
      end else if (is_inside(p1) && is_inside(p2) && p2 != BASE_G) begin
        op.context_res = CTX_CHH;
      end else if (p2 == BASE_G && p1 != BASE_C) begin
        op.context_res = CTX_CXG;
      end else begin
        op.context_res = CTX_CCG;
      end
    end else begin
      if (m1 == BASE_C) begin
        op.context_res = CTX_CPG;
      end else if (is_inside(m2) && m2 != BASE_C) begin
        op.context_res = CTX_CHH;
      end else if (m2 == BASE_C && m1 != BASE_G) begin
        op.context_res = CTX_CXG;
      end else begin
        op.context_res = CTX_CCG;
      end
    end
    op.send = op.site_ok && (!cg_only || op.context_res == CTX_CPG);
    keep = ({1'b0, in_data.position} < chrom_length) &&
           (op.emit || in_data.read_base <= BASE_T);
  end

  assign in_ready = (cnt_r != (PW+1)'(QDEPTH));
  assign push    = in_valid && in_ready && keep;
  assign pop     = q_valid && q_ready;
  assign q_valid = (cnt_r != '0);
  assign q_data  = q_mem_r[rp_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= op;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(QDEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(QDEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

### design/mpc_back.sv
// ----------------------------------------------------------------------------
// Pileup back end
// Read-modify-write of the count memory in the steps queue pop, read and
// update, one operation at a time, with an output register towards the sink.
// ----------------------------------------------------------------------------
module mpc_back
  import mpc_pkg::*;
#(
  parameter int POSITIONS  = 65536,
  parameter int COUNT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_ready,
  input  op_t       q_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW = $clog2(POSITIONS);
  localparam int EW = 8 * COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [1:0]      state_r, state_nxt;
  logic [AW:0]     clr_r;
  op_t             op_r;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [EW-1:0]   wdata, rdata;
  logic [COUNT_BITS-1:0] cnt [8];
  logic [COUNT_BITS+2:0] tot;
  logic            mut;
  logic [COUNT_BITS-1:0] unc, conv;
  logic            ovalid_r;
  out_item_t       odata_r;
  logic            fire;

  mpc_ram #(.WIDTH(EW), .DEPTH(POSITIONS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // Unpack counters and form the result.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      cnt[i] = rdata[i*COUNT_BITS +: COUNT_BITS];
    end
    if (!op_r.site_strand) begin
      tot  = (COUNT_BITS+3)'(cnt[4]) + (COUNT_BITS+3)'(cnt[5]) +
             (COUNT_BITS+3)'(cnt[6]) + (COUNT_BITS+3)'(cnt[7]);
      mut  = ({cnt[6], 1'b0} < tot[COUNT_BITS+1:0]) || tot[COUNT_BITS+2];
      unc  = cnt[1];
      conv = cnt[3];
    end else begin
      tot  = (COUNT_BITS+3)'(cnt[0]) + (COUNT_BITS+3)'(cnt[1]) +
             (COUNT_BITS+3)'(cnt[2]) + (COUNT_BITS+3)'(cnt[3]);
      mut  = ({cnt[2], 1'b0} < tot[COUNT_BITS+1:0]) || tot[COUNT_BITS+2];
      unc  = cnt[5];
      conv = cnt[7];
    end
    wdata = rdata;
    if (state_r == ST_CLEAR || op_r.emit) begin
      wdata = '0;
    end else if (cnt[op_r.lane] != CMAX) begin
      wdata[op_r.lane*COUNT_BITS +: COUNT_BITS] = cnt[op_r.lane] + 1'b1;
    end
  end

  // The address is held on the current operation so the read data stays put.
  assign raddr = (state_r == ST_IDLE) ? q_data.position[AW-1:0] : op_r.position[AW-1:0];
  assign waddr = (state_r == ST_CLEAR) ? clr_r[AW-1:0] : op_r.position[AW-1:0];
  assign fire  = (state_r == ST_WRITE) && op_r.emit && op_r.send;
  assign we    = (state_r == ST_CLEAR) ||
                 ((state_r == ST_WRITE) && (!fire || !ovalid_r || out_ready));
  assign q_ready = (state_r == ST_IDLE);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == (AW+1)'(POSITIONS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (q_valid) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_WRITE;
      ST_WRITE: if (we) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (fire && we) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // Operation and result registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && q_valid) begin
      op_r <= q_data;
    end
    if (fire && we) begin
      odata_r.site_position <= op_r.position;
      odata_r.site_strand   <= op_r.site_strand;
      odata_r.context_res   <= op_r.context_res;
      odata_r.mutated       <= mut;
      odata_r.unconverted   <= 16'(unc);
      odata_r.converted     <= 16'(conv);
    end
  end

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

endmodule

### design/mpc_checker.sv
// ----------------------------------------------------------------------------
// Methylation pileup counter checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module mpc_checker
  import mpc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A result held back by the sink stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A result is never shown in the cycle after reset.
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The input queue is empty and ready straight after reset.
  a_ready_rst: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("queue not ready after reset");

  // The queue only fills up after a request has been taken.
  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("ready dropped without a request");

endmodule

bind methylation_pileup_counter mpc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
